### rtl/led_matrix_scan_driver_unit_assert.svh
// Assertion macros shared by the checker of the LED matrix scan driver.
`ifndef LED_MATRIX_SCAN_DRIVER_UNIT_ASSERT_SVH
`define LED_MATRIX_SCAN_DRIVER_UNIT_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define LMSD_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define LMSD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/lmsd_pkg.sv
// Package with types, constants and helper functions of the LED matrix scan driver.
`timescale 1ns / 1ps
`default_nettype none
package lmsd_pkg;
	localparam int MATRIX_SIZE = 8;
	localparam int LINE_W = $clog2(MATRIX_SIZE);
	localparam int ORDER_W = MATRIX_SIZE * LINE_W;
	localparam int POS_W = LINE_W + 1;
	localparam int KIND_W = 2;
	localparam int PIX_W = 8;

	typedef logic [LINE_W-1:0] line_t;
	typedef logic [MATRIX_SIZE-1:0] bits_t;
	typedef logic [ORDER_W-1:0] order_t;
	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_SET = 2'd0;
	localparam kind_t KIND_CLEAR = 2'd1;
	localparam kind_t KIND_SCAN = 2'd2;
	localparam kind_t KIND_NONE = 2'd3;

	localparam logic REG_COL_ORDER = 1'b0;
	localparam logic REG_ROW_ORDER = 1'b1;

	localparam order_t COL_ORDER_RST = 24'd11744194;
	localparam order_t ROW_ORDER_RST = 24'd8300614;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	function automatic line_t entry_of(input order_t ord, input line_t k);
		return ord[LINE_W*k +: LINE_W];
	endfunction

	// The highest row-order entry that names the position wins.
	function automatic logic row_pick(input bits_t bits, input order_t ord, input line_t pos);
		logic r;
		r = 1'b0;
		for (int k = 0; k < MATRIX_SIZE; k++) begin
			if (ord[LINE_W*k +: LINE_W] == pos) begin
				r = bits[k];
			end
		end
		return r;
	endfunction
endpackage
`default_nettype wire

### rtl/lmsd_if.sv
// Channel interfaces for input requests and scan results.
`timescale 1ns / 1ps
`default_nettype none
interface lmsd_in_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [7:0] pixel_index;
	modport source(output valid, output kind, output pixel_index, input ready);
	modport sink(input valid, input kind, input pixel_index, output ready);
endinterface

interface lmsd_out_if;
	logic valid;
	logic ready;
	logic col_bit;
	logic row_bit;
	logic latch;
	logic last;
	logic status;
	modport source(output valid, output col_bit, output row_bit, output latch, output last,
		output status, input ready);
	modport sink(input valid, input col_bit, input row_bit, input latch, input last,
		input status, output ready);
endinterface
`default_nettype wire

### rtl/lmsd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module lmsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

### rtl/lmsd_ctrl.sv
// Sequencer that reads, updates and scans the frame memory and drives the result register.
`timescale 1ns / 1ps
`default_nettype none
module lmsd_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	lmsd_in_if.sink item,
	lmsd_out_if.source result,
	input wire lmsd_pkg::order_t col_order,
	input wire lmsd_pkg::order_t row_order
);
	import lmsd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SET = 3'd1;
	localparam logic [2:0] ST_ACK = 3'd2;
	localparam logic [2:0] ST_SCAN_RD = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;
	localparam logic [POS_W-1:0] POS_LATCH = POS_W'(MATRIX_SIZE);

	logic [2:0] state_q;
	line_t line_q;
	line_t addr_q;
	line_t bit_sel_q;
	logic [POS_W-1:0] pos_q;
	bits_t bits_q;
	bits_t valid_q;
	logic status_q;

	logic ovalid_q;
	logic col_q;
	logic row_q;
	logic latch_q;
	logic last_q;
	logic ostat_q;

	logic accept;
	logic out_free;
	logic out_load;
	logic in_range;
	logic rd_en;
	line_t rd_addr;
	bits_t rd_data;
	bits_t rd_eff;
	logic wr_en;
	bits_t wr_data;

	assign item.ready = (state_q == ST_IDLE);
	assign accept = item.valid && item.ready;
	assign out_free = !ovalid_q || result.ready;
	assign out_load = ((state_q == ST_ACK) || (state_q == ST_SCAN)) && out_free;
	assign in_range = (item.pixel_index[PIX_W-1:LINE_W*2] == '0);

	assign rd_en = accept && ((item.kind == KIND_SET && in_range) || item.kind == KIND_SCAN);
	assign rd_addr = (item.kind == KIND_SCAN) ? line_q : item.pixel_index[LINE_W*2-1:LINE_W];
	assign rd_eff = valid_q[addr_q] ? rd_data : '0;
	assign wr_en = (state_q == ST_SET);
	assign wr_data = rd_eff | (bits_t'(1) << bit_sel_q);

	lmsd_ram #(
		.WIDTH(MATRIX_SIZE),
		.DEPTH(MATRIX_SIZE)
	) u_frame (
		.clk(clk),
		.we(wr_en),
		.waddr(addr_q),
		.wdata(wr_data),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_q <= rd_addr;
			bit_sel_q <= item.pixel_index[LINE_W-1:0];
		end
		if (state_q == ST_SCAN_RD) begin
			bits_q <= rd_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (result.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			line_q <= '0;
			pos_q <= '0;
			valid_q <= '0;
			status_q <= STATUS_OK;
			col_q <= 1'b0;
			row_q <= 1'b0;
			latch_q <= 1'b0;
			last_q <= 1'b0;
			ostat_q <= STATUS_OK;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (item.kind)
							KIND_SET: begin
								if (in_range) begin
									state_q <= ST_SET;
								end else begin
									status_q <= STATUS_RANGE;
									state_q <= ST_ACK;
								end
							end
							KIND_CLEAR: begin
								valid_q <= '0;
								status_q <= STATUS_OK;
								state_q <= ST_ACK;
							end
							KIND_SCAN: begin
								state_q <= ST_SCAN_RD;
							end
							KIND_NONE: begin
								state_q <= ST_IDLE;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SET: begin
					valid_q[addr_q] <= 1'b1;
					status_q <= STATUS_OK;
					state_q <= ST_ACK;
				end
				ST_ACK: begin
					if (out_free) begin
						col_q <= 1'b0;
						row_q <= 1'b0;
						latch_q <= 1'b0;
						last_q <= 1'b1;
						ostat_q <= status_q;
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN_RD: begin
					pos_q <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (out_free) begin
						ostat_q <= STATUS_OK;
						if (pos_q == POS_LATCH) begin
							col_q <= 1'b0;
							row_q <= 1'b0;
							latch_q <= 1'b1;
							last_q <= 1'b1;
							line_q <= line_q + 1'b1;
							state_q <= ST_IDLE;
						end else begin
							col_q <= (entry_of(col_order, line_q) == pos_q[LINE_W-1:0]);
							row_q <= row_pick(bits_q, row_order, pos_q[LINE_W-1:0]);
							latch_q <= 1'b0;
							last_q <= 1'b0;
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid = ovalid_q;
	assign result.col_bit = col_q;
	assign result.row_bit = row_q;
	assign result.latch = latch_q;
	assign result.last = last_q;
	assign result.status = ostat_q;
endmodule
`default_nettype wire

### rtl/led_matrix_scan_driver_unit.sv
// Top level of the LED matrix scan driver: order registers and the frame sequencer.
//
//   Channel   Direction   Handshake          Carries
//   item      in          valid / ready      kind, pixel_index
//   result    out         valid / ready      col_bit, row_bit, latch, last, status
//   cfg       in          cfg_wr_en          cfg_index, cfg_data
//
// One request is worked on at a time. A scan request is accepted, reads its line from the
// frame memory and then gives nine results, one per cycle while the result is not stalled.
// An in-range set-pixel request reads, writes back and gives its result; clear gives a result.
// The frame lines carry valid flags that reset and clear drop at once, so no clearing
// pass is needed. A stalled result register holds the sequencer until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module led_matrix_scan_driver_unit (
	input wire logic clk,
	input wire logic arst_n,
	lmsd_in_if.sink item,
	lmsd_out_if.source result,
	input wire logic cfg_wr_en,
	input wire logic cfg_index,
	input wire lmsd_pkg::order_t cfg_data
);
	import lmsd_pkg::*;

	order_t col_order_q;
	order_t row_order_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_order_q <= COL_ORDER_RST;
			row_order_q <= ROW_ORDER_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_COL_ORDER: col_order_q <= cfg_data;
				REG_ROW_ORDER: row_order_q <= cfg_data;
				default: col_order_q <= col_order_q;
			endcase
		end
	end

	lmsd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.result(result),
		.col_order(col_order_q),
		.row_order(row_order_q)
	);
endmodule
`default_nettype wire

### rtl/lmsd_checker.sv
// Port-level checker for the LED matrix scan driver and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "led_matrix_scan_driver_unit_assert.svh"
module lmsd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire logic col_bit,
	input wire logic row_bit,
	input wire logic latch,
	input wire logic last,
	input wire logic status
);
	`LMSD_ASSERT_SAME(a_latch_last, clk, arst_n, res_valid && latch, last, "Latch result must end the request.")
	`LMSD_ASSERT_SAME(a_latch_quiet, clk, arst_n, res_valid && latch, !col_bit && !row_bit && !status, "Latch result carries data bits.")
	`LMSD_ASSERT_SAME(a_error_single, clk, arst_n, res_valid && status, last && !latch && !col_bit && !row_bit, "Range error result is malformed.")
	`LMSD_ASSERT_NEXT(a_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable({col_bit, row_bit, latch, last, status}), "Stalled result changed.")
endmodule

bind led_matrix_scan_driver_unit lmsd_checker u_lmsd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.col_bit(result.col_bit),
	.row_bit(result.row_bit),
	.latch(result.latch),
	.last(result.last),
	.status(result.status)
);
`default_nettype wire

### dv/led_matrix_scan_driver_unit_test.sv
// Self-checking testbench for the LED matrix scan driver: pixel writes, clears, scans and order registers.
`timescale 1ns / 1ps
module led_matrix_scan_driver_unit_test;
	import lmsd_pkg::*;

	localparam int PIXELS = MATRIX_SIZE * MATRIX_SIZE;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic col_bit;
		logic row_bit;
		logic latch;
		logic last;
		logic status;
	} pulse_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_index;
	order_t cfg_data;
	logic no_idle;

	lmsd_in_if item_ch();
	lmsd_out_if result_ch();

	led_matrix_scan_driver_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch.sink),
		.result(result_ch.source),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	bits_t frame_model [MATRIX_SIZE];
	line_t scan_line_model;
	order_t col_order_model;
	order_t row_order_model;
	pulse_t expected_pulses [$];
	int mismatch_count;
	int cycle_count;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("led_matrix_scan_driver_unit_test: errors");
			$finish;
		end
	end

	always @(negedge clk) begin
		result_ch.ready <= no_idle || ($urandom_range(99) >= 30);
	end

	// Every accepted result is matched against the oldest predicted one.
	always @(posedge clk) begin
		pulse_t got;
		pulse_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = '{result_ch.col_bit, result_ch.row_bit, result_ch.latch, result_ch.last,
				result_ch.status};
			if (expected_pulses.size() == 0) begin
				$display("%0t: unexpected result col %b row %b latch %b last %b status %b",
					$time, got.col_bit, got.row_bit, got.latch, got.last, got.status);
				mismatch_count++;
			end else begin
				want = expected_pulses.pop_front();
				if (got !== want) begin
					$display({"%0t: expected col %b row %b latch %b last %b status %b, ",
						"actual col %b row %b latch %b last %b status %b"},
						$time, want.col_bit, want.row_bit, want.latch, want.last, want.status,
						got.col_bit, got.row_bit, got.latch, got.last, got.status);
					mismatch_count++;
				end
			end
		end
	end

	task automatic predict_request(input kind_t req_kind, input logic [PIX_W-1:0] idx);
		pulse_t p;
		line_t colpos;
		bits_t bits;
		p = '0;
		case (req_kind)
			KIND_SET: begin
				p.last = 1'b1;
				if (idx >= PIXELS) begin
					p.status = STATUS_RANGE;
				end else begin
					frame_model[idx[5:3]][idx[2:0]] = 1'b1;
				end
				expected_pulses.push_back(p);
			end
			KIND_CLEAR: begin
				for (int l = 0; l < MATRIX_SIZE; l++) begin
					frame_model[l] = '0;
				end
				p.last = 1'b1;
				expected_pulses.push_back(p);
			end
			KIND_SCAN: begin
				colpos = col_order_model[LINE_W*scan_line_model +: LINE_W];
				bits = frame_model[scan_line_model];
				for (int pos = 0; pos < MATRIX_SIZE; pos++) begin
					p = '0;
					p.col_bit = (pos == colpos);
					// Later row entries override earlier ones for the same position.
					for (int e = 0; e < MATRIX_SIZE; e++) begin
						if (row_order_model[LINE_W*e +: LINE_W] == pos) begin
							p.row_bit = bits[e];
						end
					end
					expected_pulses.push_back(p);
				end
				p = '0;
				p.latch = 1'b1;
				p.last = 1'b1;
				expected_pulses.push_back(p);
				scan_line_model = scan_line_model + 1'b1;
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_request(input kind_t req_kind, input logic [PIX_W-1:0] idx);
		while (!no_idle && $urandom_range(99) < 30) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
		end
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.kind <= req_kind;
		item_ch.pixel_index <= idx;
		@(posedge clk);
		while (!item_ch.ready) begin
			@(posedge clk);
		end
		predict_request(req_kind, idx);
	endtask

	task automatic send_random_request();
		int pick;
		logic [PIX_W-1:0] idx;
		pick = $urandom_range(99);
		idx = PIX_W'($urandom_range(PIXELS - 1));
		if ($urandom_range(9) == 0) begin
			idx = PIX_W'($urandom_range(255, PIXELS));
		end
		if (pick < 45) begin
			send_request(KIND_SET, idx);
		end else if (pick < 85) begin
			send_request(KIND_SCAN, PIX_W'($urandom_range(255)));
		end else if (pick < 93) begin
			send_request(KIND_CLEAR, PIX_W'($urandom_range(255)));
		end else begin
			send_request(KIND_NONE, PIX_W'($urandom_range(255)));
		end
	endtask

	// Stops new requests and waits until the block has nothing left in flight.
	task automatic wait_quiet();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (expected_pulses.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_order(input logic reg_index, input order_t value);
		wait_quiet();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= reg_index;
		cfg_data <= value;
		@(posedge clk);
		if (reg_index == REG_COL_ORDER) begin
			col_order_model = value;
		end else begin
			row_order_model = value;
		end
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic order_t random_order();
		line_t perm [MATRIX_SIZE];
		line_t tmp;
		int j;
		order_t packed_order;
		if ($urandom_range(1) == 0) begin
			packed_order = order_t'($urandom);
		end else begin
			for (int i = 0; i < MATRIX_SIZE; i++) begin
				perm[i] = line_t'(i);
			end
			for (int i = MATRIX_SIZE - 1; i > 0; i--) begin
				j = $urandom_range(i);
				tmp = perm[i];
				perm[i] = perm[j];
				perm[j] = tmp;
			end
			for (int i = 0; i < MATRIX_SIZE; i++) begin
				packed_order[LINE_W*i +: LINE_W] = perm[i];
			end
		end
		return packed_order;
	endfunction

	task automatic test_directed_pixels();
		send_request(KIND_SET, 8'd0);
		send_request(KIND_SET, 8'd63);
		send_request(KIND_SET, 8'd64);
		send_request(KIND_SET, 8'd255);
		send_request(KIND_SET, 8'd200);
		send_request(KIND_SET, 8'd9);
		send_request(KIND_SET, 8'd54);
		send_request(KIND_NONE, 8'd255);
		send_request(KIND_SCAN, 8'd0);
		send_request(KIND_SCAN, 8'd170);
		send_request(KIND_CLEAR, 8'd85);
		send_request(KIND_SCAN, 8'd0);
		send_request(KIND_SET, 8'd31);
		send_request(KIND_SCAN, 8'd0);
		send_request(KIND_SET, 8'd60);
		send_request(KIND_SCAN, 8'd255);
	endtask

	task automatic test_order_extremes();
		order_t extremes [2];
		extremes[0] = '0;
		extremes[1] = '1;
		foreach (extremes[n]) begin
			write_order(REG_COL_ORDER, extremes[n]);
			write_order(REG_ROW_ORDER, extremes[n]);
			repeat (8) begin
				send_request(KIND_SET, PIX_W'($urandom_range(PIXELS - 1)));
				send_request(KIND_SCAN, PIX_W'($urandom_range(255)));
			end
		end
	endtask

	task automatic test_random_orders();
		repeat (4) begin
			write_order(REG_COL_ORDER, random_order());
			write_order(REG_ROW_ORDER, random_order());
			repeat (45) send_random_request();
		end
	endtask

	task automatic test_back_to_back();
		wait_quiet();
		no_idle = 1'b1;
		repeat (40) send_random_request();
		wait_quiet();
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		no_idle = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_COL_ORDER;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_SET;
		item_ch.pixel_index = '0;
		result_ch.ready = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		for (int l = 0; l < MATRIX_SIZE; l++) begin
			frame_model[l] = '0;
		end
		scan_line_model = '0;
		col_order_model = COL_ORDER_RST;
		row_order_model = ROW_ORDER_RST;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_pixels();
		test_order_extremes();
		test_random_orders();
		test_back_to_back();

		wait_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_pulses.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_pulses.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("led_matrix_scan_driver_unit_test: clean");
		end else begin
			$display("led_matrix_scan_driver_unit_test: errors");
		end
		$finish;
	end
endmodule

### led_matrix_scan_driver_unit.f
+incdir+rtl
rtl/lmsd_pkg.sv
rtl/lmsd_if.sv
rtl/lmsd_ram.sv
rtl/lmsd_ctrl.sv
rtl/led_matrix_scan_driver_unit.sv
rtl/lmsd_checker.sv
dv/led_matrix_scan_driver_unit_test.sv
